[rtl/vnsm_pkg.sv]
// Shared widths, register indexes and types for the viewport nearest scaler map.
package vnsm_pkg;

  // Blit buffer limits
  localparam int unsigned MAX_BLIT_W = 320;
  localparam int unsigned MAX_BLIT_H = 200;

  // Field widths
  localparam int unsigned COL_W   = 9;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned VIEW_W  = 12;
  localparam int unsigned IMG_W   = 16;
  localparam int unsigned PAN_W   = 17;
  localparam int unsigned ZOOM_W  = 13;
  localparam int unsigned SRC_W   = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_X        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_Y        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM         = 3'd6;

  // Reset values of the registers
  localparam logic [VIEW_W-1:0] RST_VIEW_WIDTH   = 12'd320;
  localparam logic [VIEW_W-1:0] RST_VIEW_HEIGHT  = 12'd200;
  localparam logic [IMG_W-1:0]  RST_IMAGE_WIDTH  = 16'd320;
  localparam logic [IMG_W-1:0]  RST_IMAGE_HEIGHT = 16'd200;
  localparam logic [PAN_W-1:0]  RST_PAN          = 17'd0;
  localparam logic [ZOOM_W-1:0] RST_ZOOM         = 13'd1000;

  // Datapath widths
  localparam int unsigned COORD_W = VIEW_W;            // coordinate widened for compares
  localparam int unsigned BLIT_CW = 10;                // coordinate below a capped blit size
  localparam int unsigned PROD_W  = BLIT_CW + VIEW_W;  // coordinate times viewport size
  localparam int unsigned DIFF_W  = PAN_W + 1;         // viewport coordinate minus pan
  localparam int unsigned MAG_W   = PAN_W;             // magnitude of that difference
  localparam int unsigned NUM_W   = 27;                // magnitude times 1000
  localparam int unsigned SCALE_W = 10;
  localparam logic [SCALE_W-1:0] SCALE_PERMILLE = 10'd1000;
  localparam logic [ZOOM_W-1:0]  ZOOM_UNITY     = 13'd1000;

  // Divider pipeline: quotient bits resolved per stage
  localparam int unsigned DIV_STEP   = 3;
  localparam int unsigned DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned DIV_BITS   = DIV_STAGES * DIV_STEP;

  // Pipeline stage positions
  localparam int unsigned ST_A   = 0;  // blit compare, coordinate times view
  localparam int unsigned ST_B   = 1;  // reciprocal multiply
  localparam int unsigned ST_C   = 2;  // quotient correction, viewport coordinate
  localparam int unsigned ST_D   = 3;  // subtract pan, magnitude
  localparam int unsigned ST_E   = 4;  // times 1000
  localparam int unsigned ST_DIV = 5;  // first divider stage
  localparam int unsigned ST_OUT = ST_DIV + DIV_STAGES;
  localparam int unsigned N_ST   = ST_OUT + 1;

  // Flags that ride along the divider
  typedef struct packed {
    logic ok;   // coordinate lies in the blit buffer
    logic neg;  // difference to the origin is negative
  } div_tag_t;

endpackage

[rtl/vnsm_div_pipe.sv]
// Pipelined unsigned restoring divider, a few quotient bits per stage.
module vnsm_div_pipe import vnsm_pkg::*; (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [ZOOM_W-1:0]     den_i,
  input  div_tag_t              tag_i,
  output logic [NUM_W-1:0]      quot_o,
  output div_tag_t              tag_o
);

  logic [ZOOM_W-1:0]   rem_q  [DIV_STAGES];
  logic [DIV_BITS-1:0] work_q [DIV_STAGES];
  div_tag_t            tag_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [ZOOM_W-1:0]   rem_in;
    logic [DIV_BITS-1:0] work_in;
    div_tag_t            tag_in;
    logic [ZOOM_W-1:0]   rem_d;
    logic [DIV_BITS-1:0] work_d;

    // Take the previous stage, or the fresh numerator at the head
    if (s == 0) begin : g_head
      assign rem_in  = '0;
      assign work_in = DIV_BITS'(num_i);
      assign tag_in  = tag_i;
    end else begin : g_body
      assign rem_in  = rem_q[s-1];
      assign work_in = work_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    // Shift in numerator bits, subtract the divisor where it fits
    always_comb begin
      logic [ZOOM_W:0]     trial;
      logic [ZOOM_W-1:0]   rem;
      logic [DIV_BITS-1:0] work;
      rem  = rem_in;
      work = work_in;
      for (int unsigned k = 0; k < DIV_STEP; k++) begin
        trial = {rem, work[DIV_BITS-1]};
        work  = {work[DIV_BITS-2:0], 1'b0};
        if (trial >= {1'b0, den_i}) begin
          trial   = trial - {1'b0, den_i};
          work[0] = 1'b1;
        end
        rem = trial[ZOOM_W-1:0];
      end
      rem_d  = rem;
      work_d = work;
    end

    // Advance when the stage may take a new word
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_d;
        work_q[s] <= work_d;
        tag_q[s]  <= tag_in;
      end
    end
  end

  assign quot_o = work_q[DIV_STAGES-1][NUM_W-1:0];
  assign tag_o  = tag_q[DIV_STAGES-1];

endmodule

[rtl/viewport_nearest_scaler_map.sv]
// Top level of the viewport nearest scaler map: registers, pipeline control, both axes.
//
// Usage:
//   Input channel: in_valid_i with out_col_i / out_row_i, a word is taken at a rising
//   edge with in_valid_i high and in_stall_o low. Output channel: out_valid_o with
//   src_col_o / src_row_o / inside_res_o, a word leaves at an edge with out_valid_o
//   high and out_stall_i low. Every input word gives exactly one output word, in order.
//   Configuration: cfg_valid_i with cfg_index_i / cfg_data_i; cfg_ready_o is always
//   high, so a write lands on the edge it is presented. Write only while idle.
//   A word passes through 15 register stages on its way to the output register: 5 front
//   stages, 9 divider stages of 3 quotient bits each, 1 output stage. Throughput: one
//   word per cycle while the receiver does not stall.
//   The divider stages set the depth; each resolves 3 bits of the 27-bit quotient.
//   Reset clears all valid bits and loads the register defaults (320x200 view and
//   image, zero pan, zoom 1000). When the receiver stalls, words stack up in empty
//   stages; in_stall_o rises only once every stage holds a word.
module viewport_nearest_scaler_map import vnsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COL_W-1:0]      out_col_i,
  input  logic [ROW_W-1:0]      out_row_i,
  // output words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SRC_W-1:0]      src_col_o,
  output logic [SRC_W-1:0]      src_row_o,
  output logic                  inside_res_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [VIEW_W-1:0] view_width_q, view_height_q;
  logic [IMG_W-1:0]  image_width_q, image_height_q;
  logic [PAN_W-1:0]  pan_x_q, pan_y_q;
  logic [ZOOM_W-1:0] zoom_q;

  assign cfg_ready_o = 1'b1;

  // Load a register on each write; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_width_q   <= RST_VIEW_WIDTH;
      view_height_q  <= RST_VIEW_HEIGHT;
      image_width_q  <= RST_IMAGE_WIDTH;
      image_height_q <= RST_IMAGE_HEIGHT;
      pan_x_q        <= RST_PAN;
      pan_y_q        <= RST_PAN;
      zoom_q         <= RST_ZOOM;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_VIEW_WIDTH:   view_width_q   <= cfg_data_i[VIEW_W-1:0];
        CFG_VIEW_HEIGHT:  view_height_q  <= cfg_data_i[VIEW_W-1:0];
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[IMG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[IMG_W-1:0];
        CFG_PAN_X:        pan_x_q        <= cfg_data_i[PAN_W-1:0];
        CFG_PAN_Y:        pan_y_q        <= cfg_data_i[PAN_W-1:0];
        CFG_ZOOM:         zoom_q         <= cfg_data_i[ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero zoom stands for unity
  logic [ZOOM_W-1:0] zoom_eff;
  assign zoom_eff = (zoom_q == '0) ? ZOOM_UNITY : zoom_q;

  // Pipeline control: a stage loads when empty or when its successor moves
  logic [N_ST-1:0] valid_q;
  logic [N_ST:0]   ready;

  always_comb begin
    ready[N_ST] = !out_stall_i;
    for (int k = N_ST - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[ST_A]) begin
        valid_q[ST_A] <= in_valid_i;
      end
      for (int unsigned k = 1; k < N_ST; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Per-axis views of the inputs and registers
  logic [COORD_W-1:0] coord    [2];
  logic [VIEW_W-1:0]  view_sz  [2];
  logic [IMG_W-1:0]   image_sz [2];
  logic [PAN_W-1:0]   pan      [2];

  assign coord[0]    = COORD_W'(out_col_i);
  assign coord[1]    = COORD_W'(out_row_i);
  assign view_sz[0]  = view_width_q;
  assign view_sz[1]  = view_height_q;
  assign image_sz[0] = image_width_q;
  assign image_sz[1] = image_height_q;
  assign pan[0]      = pan_x_q;
  assign pan[1]      = pan_y_q;

  logic [NUM_W-1:0] quot    [2];
  div_tag_t         div_tag [2];
  logic             axis_in [2];

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    localparam int unsigned MAXB    = (ax == 0) ? MAX_BLIT_W : MAX_BLIT_H;
    localparam int unsigned RECIP   = (1 << PROD_W) / MAXB;
    localparam int unsigned RECIP_W = $clog2(RECIP + 1);
    localparam int unsigned MUL_W   = PROD_W + RECIP_W;

    // stage A
    logic [PROD_W-1:0]  a_prod_q;
    logic [BLIT_CW-1:0] a_c_q;
    logic               a_ok_q, a_dir_q;
    // stage B
    logic [PROD_W-1:0]  b_prod_q;
    logic [VIEW_W-1:0]  b_qe_q;
    logic [BLIT_CW-1:0] b_c_q;
    logic               b_ok_q, b_dir_q;
    // stage C
    logic [VIEW_W-1:0]  c_vp_q;
    logic               c_ok_q;
    // stage D
    logic [MAG_W-1:0]   d_mag_q;
    logic               d_neg_q, d_ok_q;
    // stage E
    logic [NUM_W-1:0]   e_num_q;
    div_tag_t           e_tag_q;

    logic [VIEW_W-1:0]  blit;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  rem_c;
    logic [VIEW_W-1:0]  vp_c;
    logic [DIFF_W-1:0]  diff_d;
    logic [MAG_W-1:0]   mag_d;

    // Cap the viewport at the blit limit
    assign blit = (view_sz[ax] > VIEW_W'(MAXB)) ? VIEW_W'(MAXB) : view_sz[ax];

    // Reciprocal estimate of the product over the blit limit
    assign mul_b = MUL_W'(a_prod_q) * MUL_W'(RECIP);

    // Bypass when the view fits; else add one where the remainder reaches the limit
    always_comb begin
      rem_c = b_prod_q - PROD_W'(b_qe_q) * PROD_W'(MAXB);
      if (b_dir_q) begin
        vp_c = VIEW_W'(b_c_q);
      end else if (rem_c >= PROD_W'(MAXB)) begin
        vp_c = b_qe_q + VIEW_W'(1);
      end else begin
        vp_c = b_qe_q;
      end
    end

    // Subtract the sign-extended origin and take the magnitude
    always_comb begin
      diff_d = DIFF_W'(c_vp_q) - {pan[ax][PAN_W-1], pan[ax]};
      mag_d  = diff_d[DIFF_W-1] ? MAG_W'(-diff_d) : diff_d[MAG_W-1:0];
    end

    // Front stages
    always_ff @(posedge clk_i) begin
      if (ready[ST_A]) begin
        a_prod_q <= PROD_W'(coord[ax][BLIT_CW-1:0]) * PROD_W'(view_sz[ax]);
        a_c_q    <= coord[ax][BLIT_CW-1:0];
        a_ok_q   <= coord[ax] < blit;
        a_dir_q  <= view_sz[ax] <= VIEW_W'(MAXB);
      end
      if (ready[ST_B]) begin
        b_prod_q <= a_prod_q;
        b_qe_q   <= mul_b[PROD_W +: VIEW_W];
        b_c_q    <= a_c_q;
        b_ok_q   <= a_ok_q;
        b_dir_q  <= a_dir_q;
      end
      if (ready[ST_C]) begin
        c_vp_q <= vp_c;
        c_ok_q <= b_ok_q;
      end
      if (ready[ST_D]) begin
        d_mag_q <= mag_d;
        d_neg_q <= diff_d[DIFF_W-1];
        d_ok_q  <= c_ok_q;
      end
      if (ready[ST_E]) begin
        e_num_q     <= NUM_W'(d_mag_q) * NUM_W'(SCALE_PERMILLE);
        e_tag_q.ok  <= d_ok_q;
        e_tag_q.neg <= d_neg_q;
      end
    end

    vnsm_div_pipe u_div (
      .clk_i  (clk_i),
      .en_i   (ready[ST_DIV +: DIV_STAGES]),
      .num_i  (e_num_q),
      .den_i  (zoom_eff),
      .tag_i  (e_tag_q),
      .quot_o (quot[ax]),
      .tag_o  (div_tag[ax])
    );

    // Negative quotients other than zero fall left of or above the image
    assign axis_in[ax] = div_tag[ax].ok && (!div_tag[ax].neg || quot[ax] == '0)
                         && (quot[ax] < NUM_W'(image_sz[ax]));
  end

  // Output register: zero the coordinates of background pixels
  logic             inside_d;
  logic [SRC_W-1:0] src_col_q, src_row_q;
  logic             inside_q;

  assign inside_d = axis_in[0] && axis_in[1];

  always_ff @(posedge clk_i) begin
    if (ready[ST_OUT]) begin
      src_col_q <= inside_d ? quot[0][SRC_W-1:0] : '0;
      src_row_q <= inside_d ? quot[1][SRC_W-1:0] : '0;
      inside_q  <= inside_d;
    end
  end

  assign src_col_o    = src_col_q;
  assign src_row_o    = src_row_q;
  assign inside_res_o = inside_q;

`ifndef SYNTHESIS
  a_bg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_res_o |-> src_col_o == '0 && src_row_o == '0)
    else $error("background word carries nonzero coordinates");

  a_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && inside_res_o |-> src_col_o < image_width_q && src_row_o < image_height_q)
    else $error("inside word maps beyond the image");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  a_fill_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_OUT-1] && !valid_q[ST_OUT] |=> valid_q[ST_OUT])
    else $error("word lost before the output register");
`endif

endmodule
